### design/sdpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdpu_pkg;
    localparam int BIAS_FRAC_BITS = 16;
    localparam int DEPTH_W = 24;
    localparam int PEN_W = 8;
    localparam int NUM2_W = PEN_W + BIAS_FRAC_BITS;
    localparam int DIV1_STEPS = DEPTH_W;
    // transitions: term quotient bits, divisor forming, penumbra quotient bits
    localparam int STAGES = DIV1_STEPS + 1 + NUM2_W;
    localparam int FIFO_DEPTH = 2;
    localparam logic [1:0] REG_BIAS_CONSTANT = 2'd0;
    localparam logic [1:0] REG_BIAS_LINEAR = 2'd1;

    typedef struct packed {
        logic [31:0] spix;
        logic [DEPTH_W-1:0] fdepth;
        logic [PEN_W-1:0] fpen;
        logic neg;
        logic [2*DEPTH_W-1:0] mag;
    } front_t;

    typedef struct packed {
        logic [31:0] spix;
        logic [DEPTH_W-1:0] fdepth;
        logic [PEN_W-1:0] fpen;
        logic neg;
        logic [DEPTH_W-1:0] rem1;
        logic [DEPTH_W-1:0] num1;
        logic [DEPTH_W-1:0] q1;
        logic signed [DEPTH_W+1:0] div2;
        logic [DEPTH_W:0] rem2;
        logic [NUM2_W-1:0] num2;
        logic [NUM2_W-1:0] q2;
    } back_t;
endpackage
`default_nettype wire

### design/sdpu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sdpu_front (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [31:0] stored_pixel,
    input  wire logic [23:0] fragment_depth,
    input  wire logic [7:0] fragment_penumbra,
    input  wire logic [23:0] bias_linear,
    output logic out_valid,
    input  wire logic out_ready,
    output sdpu_pkg::front_t out_item
);
    logic valid_reg, valid_next;
    sdpu_pkg::front_t item_reg, item_next;
    logic [23:0] abs_bl;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item = item_reg;

    // magnitude product of the depth ratio term
    always_comb begin
        abs_bl = bias_linear[23] ? (~bias_linear + 24'd1) : bias_linear;
        item_next.spix = stored_pixel;
        item_next.fdepth = fragment_depth;
        item_next.fpen = fragment_penumbra;
        item_next.neg = bias_linear[23];
        item_next.mag = abs_bl * fragment_depth;
        valid_next = valid_reg;
        if (in_ready) valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else valid_reg <= valid_next;
        if (in_ready && in_valid) item_reg <= item_next;
    end
endmodule
`default_nettype wire

### design/sdpu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module sdpu_fifo (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire sdpu_pkg::front_t push_item,
    output logic full,
    input  wire logic pop,
    output logic not_empty,
    output sdpu_pkg::front_t pop_item
);
    sdpu_pkg::front_t mem_reg [sdpu_pkg::FIFO_DEPTH];
    logic wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'(sdpu_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_item = mem_reg[rptr_reg];

    // pointer and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop) rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wptr_reg] <= push_item;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(sdpu_pkg::FIFO_DEPTH)) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

### design/sdpu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sdpu_back (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic in_take,
    input  wire sdpu_pkg::front_t in_item,
    input  wire logic [23:0] bias_constant,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [31:0] updated_pixel,
    output logic pixel_changed,
    output logic [7:0] shadow_level
);
    localparam int S = sdpu_pkg::STAGES;
    localparam int NW = sdpu_pkg::NUM2_W;

    sdpu_pkg::back_t st_reg [S+1];
    sdpu_pkg::back_t st_next [S+1];
    logic [S:0] v_reg;
    logic en;
    logic out_valid_reg;
    logic [31:0] pix_reg, pix_next;
    logic chg_reg, chg_next;
    logic [7:0] lvl_reg, lvl_next;

    // whole pipe holds only while the output waits
    assign en = !out_valid_reg || out_ready;
    assign in_take = en && in_valid;
    assign out_valid = out_valid_reg;
    assign updated_pixel = pix_reg;
    assign pixel_changed = chg_reg;
    assign shadow_level = lvl_reg;

    // one quotient bit per stage, divisor formed in between
    always_comb begin
        logic [24:0] rr1;
        logic [25:0] rr2;
        logic [23:0] sd;
        st_next[0] = '0;
        st_next[0].spix = in_item.spix;
        st_next[0].fdepth = in_item.fdepth;
        st_next[0].fpen = in_item.fpen;
        st_next[0].neg = in_item.neg;
        st_next[0].rem1 = in_item.mag[47:24];
        st_next[0].num1 = in_item.mag[23:0];
        for (int i = 0; i < S; i++) begin
            st_next[i+1] = st_reg[i];
            sd = st_reg[i].spix[31:8];
            rr1 = {st_reg[i].rem1, st_reg[i].num1[23]};
            rr2 = {st_reg[i].rem2, st_reg[i].num2[NW-1]};
            if (i < sdpu_pkg::DIV1_STEPS) begin
                st_next[i+1].num1 = {st_reg[i].num1[22:0], 1'b0};
                if (rr1 >= {1'b0, sd}) begin
                    st_next[i+1].rem1 = 24'(rr1 - {1'b0, sd});
                    st_next[i+1].q1 = {st_reg[i].q1[22:0], 1'b1};
                end else begin
                    st_next[i+1].rem1 = rr1[23:0];
                    st_next[i+1].q1 = {st_reg[i].q1[22:0], 1'b0};
                end
            end else if (i == sdpu_pkg::DIV1_STEPS) begin
                st_next[i+1].div2 = $signed({{2{bias_constant[23]}}, bias_constant})
                    + (st_reg[i].neg ? -$signed({2'b00, st_reg[i].q1})
                                     : $signed({2'b00, st_reg[i].q1}));
                st_next[i+1].rem2 = '0;
                st_next[i+1].num2 = {st_reg[i].fpen, {sdpu_pkg::BIAS_FRAC_BITS{1'b0}}};
                st_next[i+1].q2 = '0;
            end else begin
                st_next[i+1].num2 = {st_reg[i].num2[NW-2:0], 1'b0};
                if (rr2 >= {1'b0, st_reg[i].div2[24:0]}) begin
                    st_next[i+1].rem2 = 25'(rr2 - {1'b0, st_reg[i].div2[24:0]});
                    st_next[i+1].q2 = {st_reg[i].q2[NW-2:0], 1'b1};
                end else begin
                    st_next[i+1].rem2 = rr2[24:0];
                    st_next[i+1].q2 = {st_reg[i].q2[NW-2:0], 1'b0};
                end
            end
        end
    end

    // result selection from the last stage
    always_comb begin
        logic [23:0] sd;
        logic [7:0] sp;
        logic nearer;
        sd = st_reg[S].spix[31:8];
        sp = st_reg[S].spix[7:0];
        nearer = st_reg[S].fdepth < sd;
        pix_next = st_reg[S].spix;
        chg_next = nearer;
        lvl_next = nearer ? sp : 8'd0;
        if (nearer) begin
            if (st_reg[S].fpen == 8'd0) pix_next = {st_reg[S].fdepth, sp};
            else if (st_reg[S].div2 < 0) pix_next = {sd, 8'd0};
            else if (st_reg[S].div2 != 0 && st_reg[S].q2 < NW'(sp))
                pix_next = {sd, st_reg[S].q2[7:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg <= {v_reg[S-1:0], in_valid};
            out_valid_reg <= v_reg[S];
        end
        if (en) begin
            for (int i = 0; i <= S; i++) st_reg[i] <= st_next[i];
            pix_reg <= pix_next;
            chg_reg <= chg_next;
            lvl_reg <= lvl_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_level_far: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !pixel_changed) |-> (shadow_level == 8'd0))
        else $error("lookup nonzero for fragment not nearer");
    a_take_en: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> en) else $error("take during stall");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

### design/shadow_depth_penumbra_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shadow map pixel update and lookup. Takes one fragment per clock and
// gives one result per clock while m_tready stays high. From input transfer
// to result transfer a fragment passes the front multiply register, a two-entry
// queue, the first back stage load, 24 restoring steps for the depth ratio term,
// one divisor stage, 24 steps for the penumbra quotient and the output register.
// Not enforced by the block: the user must write the two bias registers through
// cfg_wr_en/cfg_index/cfg_data only while no fragment is in flight.
module shadow_depth_penumbra_update_unit (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic s_tvalid,
    output logic s_tready,
    // stored_pixel[31:0], fragment_depth[55:32], fragment_penumbra[63:56]
    input  wire logic [63:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // updated_pixel[31:0], pixel_changed[32], shadow_level[40:33], zero pad
    output logic [47:0] m_tdata
);
    logic [23:0] bias_constant_reg, bias_linear_reg;
    logic f_valid, f_ready, q_full, q_ne, q_pop;
    sdpu_pkg::front_t f_item, q_item;
    logic [31:0] upd;
    logic chg;
    logic [7:0] lvl;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_constant_reg <= 24'd65536;
            bias_linear_reg <= 24'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sdpu_pkg::REG_BIAS_CONSTANT: bias_constant_reg <= cfg_data;
                sdpu_pkg::REG_BIAS_LINEAR: bias_linear_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign f_ready = !q_full;

    sdpu_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .stored_pixel(s_tdata[31:0]), .fragment_depth(s_tdata[55:32]),
        .fragment_penumbra(s_tdata[63:56]), .bias_linear(bias_linear_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    sdpu_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(f_valid && f_ready), .push_item(f_item), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_item(q_item)
    );

    sdpu_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_ne), .in_take(q_pop), .in_item(q_item),
        .bias_constant(bias_constant_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .updated_pixel(upd), .pixel_changed(chg), .shadow_level(lvl)
    );

    assign m_tdata = {7'd0, lvl, chg, upd};
endmodule
`default_nettype wire

### verif/sdpu_checker.sv
`timescale 1ns / 1ps
module sdpu_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    output int               err_count,
    output int               pending
);
    typedef struct packed {
        logic [31:0] pixel;
        logic        changed;
        logic [7:0]  level;
    } shade_res_t;

    logic signed [23:0] k_const;
    logic signed [23:0] k_lin;
    shade_res_t expected_q[$];

    // work out the updated pixel and lookup level for one fragment
    function automatic shade_res_t shade_update(logic [63:0] d);
        logic [23:0] sdepth, fdepth, ndepth;
        logic [7:0] spen, fpen, npen;
        longint prod, term, divisor, scaled;
        shade_res_t r;
        sdepth = d[31:8];
        spen = d[7:0];
        fdepth = d[55:32];
        fpen = d[63:56];
        ndepth = sdepth;
        npen = spen;
        r.changed = 1'b0;
        if (fdepth < sdepth) begin
            r.changed = 1'b1;
            if (fpen == 0) begin
                ndepth = fdepth;
            end else begin
                // sv division of longint truncates toward zero
                prod = longint'(k_lin) * longint'({40'd0, fdepth});
                term = prod / longint'({40'd0, sdepth});
                divisor = longint'(k_const) + term;
                if (divisor < 0) begin
                    npen = 8'd0;
                end else if (divisor > 0) begin
                    scaled = (longint'(fpen) <<< sdpu_pkg::BIAS_FRAC_BITS) / divisor;
                    if (scaled < longint'(spen)) npen = scaled[7:0];
                end
            end
        end
        r.pixel = {ndepth, npen};
        r.level = (sdepth > fdepth) ? spen : 8'd0;
        return r;
    endfunction

    always @(posedge aclk) begin
        shade_res_t got, want;
        if (!aresetn) begin
            k_const <= 24'sd65536;
            k_lin <= 24'sd0;
            err_count <= 0;
            expected_q.delete();
        end else begin
            // config write
            if (cfg_wr_en) begin
                if (cfg_index == sdpu_pkg::REG_BIAS_CONSTANT) k_const <= cfg_data;
                else if (cfg_index == sdpu_pkg::REG_BIAS_LINEAR) k_lin <= cfg_data;
            end
            // input transfer
            if (s_tvalid && s_tready) expected_q.push_back(shade_update(s_tdata));
            // result transfer
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[32], m_tdata[40:33]};
                if (expected_q.size() == 0) begin
                    if (err_count < 10)
                        $display("unexpected result %h", m_tdata);
                    err_count <= err_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_tdata[47:41] !== 7'd0) begin
                        if (err_count < 10)
                            $display("mismatch: exp pix %h chg %b lvl %h, %s %h chg %b lvl %h",
                                     want.pixel, want.changed, want.level, "got pix",
                                     got.pixel, got.changed, got.level);
                        err_count <= err_count + 1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;
    logic s_tvalid, s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [47:0] m_tdata;
    int err_count, pending;
    bit calm;

    shadow_depth_penumbra_update_unit u_dut (.*);
    sdpu_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

    // result side stalls
    always @(negedge aclk) m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);

    // valid stays high after a transfer so items can follow back to back
    task automatic send_frag(logic [31:0] spix, logic [23:0] fd, logic [7:0] fp);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {fp, fd, spix};
        // ready only changes at rising edges, so a high value here means transfer
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic set_bias(logic [23:0] kconst, logic [23:0] klin);
        cfg_wr_en <= 1'b1;
        cfg_index <= sdpu_pkg::REG_BIAS_CONSTANT;
        cfg_data <= kconst;
        @(negedge aclk);
        cfg_index <= sdpu_pkg::REG_BIAS_LINEAR;
        cfg_data <= klin;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly nearer fragments, some equal and farther, some hard occluders
    task automatic send_random();
        logic [23:0] sd, fd;
        logic [7:0] fp;
        int pick;
        sd = 24'($urandom());
        pick = $urandom_range(9);
        if (pick < 6) fd = (sd == 0) ? 24'd0 : 24'($urandom_range(sd - 1));
        else if (pick == 6) fd = sd;
        else fd = 24'($urandom());
        if (pick == 8) sd = 24'($urandom_range(3));
        fp = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom());
        send_frag({sd, 8'($urandom())}, fd, fp);
    endtask

    initial begin
        logic [23:0] kc [7] = '{24'h010000, 24'h000001, 24'h7FFFFF, 24'h800000,
                               24'h000000, 24'h008000, 24'hFF0000};
        logic [23:0] kl [7] = '{24'h000000, 24'hFF0000, 24'h800000, 24'h7FFFFF,
                               24'h000000, 24'h010000, 24'h010000};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = sdpu_pkg::REG_BIAS_CONSTANT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: field extremes, hard occluder, equal, farther, zero/negative divisor
        send_frag(32'hFFFFFFFF, 24'h000000, 8'hFF);
        send_frag(32'hFFFFFFFF, 24'hFFFFFE, 8'h00);
        send_frag(32'h000000FF, 24'h000000, 8'h01);
        send_frag(32'h12345680, 24'h123456, 8'h40);
        send_frag(32'h10000055, 24'hFFFFFF, 8'h80);
        send_frag(32'h800000C0, 24'h400000, 8'h20);
        send_frag(32'h00000100, 24'h000000, 8'hFF);
        drain();
        set_bias(24'h000000, 24'h000000);
        send_frag(32'h80000077, 24'h100000, 8'h10);
        drain();
        set_bias(24'hFFFFFF, 24'h000000);
        send_frag(32'h80000077, 24'h100000, 8'h10);
        drain();
        set_bias(24'h010000, 24'hFF0000);
        send_frag(32'h800000AA, 24'h7FFFFF, 8'h33);
        send_frag(32'h00000233, 24'h000001, 8'hFF);

        // random phases over several bias settings
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            if (ph < 7) begin
                set_bias(kc[ph], kl[ph]);
            end else begin
                set_bias(24'($urandom_range(24'h40000)), 24'($urandom()));
            end
            calm = (ph == 3);
            for (int i = 0; i < 190; i++) send_random();
        end
        calm = 1'b0;
        drain();
        if (err_count == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule
